### design/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue; depends on nothing else.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DEQUEUED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } spq_status_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic signed [15:0] prio;
  } spq_entry_t;

  // Broadcast to every cell in the row.
  typedef struct packed {
    logic       enq;
    logic       deq;
    spq_entry_t entry;
  } spq_cmd_t;

endpackage

### design/sorted_priority_queue.sv
// Top level of the sorted priority queue: a row of spq_cell instances plus
// fill count and result register. Depends on spq_pkg and spq_cell.
`timescale 1ns / 1ps
//
//  Channel | Signals                                        | Direction
//  --------+------------------------------------------------+----------
//  request | req_valid, req_stall, opcode, entry_key,       | in
//          | entry_priority                                 |
//  result  | rsp_valid, rsp_stall, status, out_key,         | out
//          | out_priority                                   |
//
//  One operation is taken every cycle while not stalled; its result appears
//  in the result register on the cycle after the transfer. Every cell compares
//  its own priority with the newcomer at once, so an insert or removal is one
//  shift. Reset clears the fill count and the result valid; cell contents are
//  not cleared, since no cell at or above the fill count is ever read.
//  req_stall is high only while a result is held and the result side stalls.

module sorted_priority_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic                 opcode,
  input  logic signed [31:0]   entry_key,
  input  logic signed [15:0]   entry_priority,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output spq_pkg::spq_status_t status,
  output logic signed [31:0]   out_key,
  output logic signed [15:0]   out_priority
);
  import spq_pkg::*;

  logic [COUNT_W-1:0] count;
  logic               accept;
  logic               is_full;
  logic               is_empty;
  logic               enq_ok;
  logic               deq_ok;
  spq_cmd_t           cmd;

  spq_entry_t         cell_entry [CAPACITY];
  logic               cell_keep  [CAPACITY];
  logic               cell_occ   [CAPACITY];

  // A new request is taken whenever the result register is free or emptying.
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  assign is_full  = (count == COUNT_W'(CAPACITY));
  assign is_empty = (count == '0);
  assign enq_ok   = accept && (opcode == OP_ENQUEUE) && !is_full;
  assign deq_ok   = accept && (opcode == OP_DEQUEUE) && !is_empty;

  assign cmd.enq        = enq_ok;
  assign cmd.deq        = deq_ok;
  assign cmd.entry.key  = entry_key;
  assign cmd.entry.prio = entry_priority;

  // The row: cell 0 is the front. Entries move right on insert, left on removal.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_entry_t left_entry;
    logic       left_keep;
    spq_entry_t right_entry;

    assign cell_occ[i] = (count > COUNT_W'(i));

    if (i == 0) begin : g_front
      // Nothing ahead of the front cell, so it behaves as if its left
      // neighbour always outranks the newcomer.
      assign left_entry = cmd.entry;
      assign left_keep  = 1'b1;
    end else begin : g_inner
      assign left_entry = cell_entry[i-1];
      assign left_keep  = cell_keep[i-1];
    end

    if (i == CAPACITY - 1) begin : g_back
      assign right_entry = '0;
    end else begin : g_mid
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (cell_occ[i]),
      .left_entry  (left_entry),
      .left_keep   (left_keep),
      .right_entry (right_entry),
      .entry       (cell_entry[i]),
      .keep        (cell_keep[i])
    );
  end

  // Fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (enq_ok) begin
      count <= count + COUNT_W'(1);
    end else if (deq_ok) begin
      count <= count - COUNT_W'(1);
    end
  end

  // Result register. The valid flag is control state; the payload is not reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      unique case (opcode)
        OP_ENQUEUE: begin
          status       <= is_full ? ST_FULL : ST_ENQUEUED;
          out_key      <= '0;
          out_priority <= '0;
        end
        OP_DEQUEUE: begin
          if (is_empty) begin
            status       <= ST_EMPTY;
            out_key      <= '0;
            out_priority <= '0;
          end else begin
            status       <= ST_DEQUEUED;
            out_key      <= cell_entry[0].key;
            out_priority <= cell_entry[0].prio;
          end
        end
      endcase
    end
  end

  // The fill count never passes the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(CAPACITY))
    else $error("fill count above capacity");

  // A transfer into a full queue is rejected and leaves the count unchanged.
  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    accept && (opcode == OP_ENQUEUE) && is_full
    |=> rsp_valid && (status == ST_FULL) && (count == $past(count)))
    else $error("enqueue into full queue not rejected");

  // A removal returns what the front cell held.
  a_deq_front: assert property (@(posedge clk) disable iff (rst)
    deq_ok |=> (status == ST_DEQUEUED) && (out_key == $past(cell_entry[0].key))
      && (out_priority == $past(cell_entry[0].prio)))
    else $error("dequeued entry differs from front cell");

  // An accepted insert grows the count by one.
  a_enq_count: assert property (@(posedge clk) disable iff (rst)
    enq_ok |=> count == $past(count) + COUNT_W'(1))
    else $error("count not advanced on enqueue");

endmodule

### design/spq_cell.sv
// One storage cell of the sorted row: holds one entry and shifts with its neighbours.
// Depends on spq_pkg for the entry and command types.
`timescale 1ns / 1ps

module spq_cell (
  input  logic                clk,
  input  spq_pkg::spq_cmd_t   cmd,
  input  logic                occupied,
  input  spq_pkg::spq_entry_t left_entry,
  input  logic                left_keep,
  input  spq_pkg::spq_entry_t right_entry,
  output spq_pkg::spq_entry_t entry,
  output logic                keep
);
  import spq_pkg::*;

  // The entry stays where it is if it outranks the newcomer strictly.
  assign keep = occupied && (entry.prio > cmd.entry.prio);

  always_ff @(posedge clk) begin
    if (cmd.enq) begin
      priority if (keep) begin
        entry <= entry;
      end else if (left_keep) begin
        entry <= cmd.entry;
      end else begin
        entry <= left_entry;
      end
    end else if (cmd.deq) begin
      entry <= right_entry;
    end
  end

endmodule
